// ===== hw/rtl/lzp_pkg.sv =====
package lzp_pkg;

   localparam int WORD_BITS = 16;

   // operation codes on the request channel
   localparam logic OP_WORD = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic                 operation;
      logic [WORD_BITS-1:0] word;
   } req_payload_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] value;
      logic                 value_valid;
      logic                 run_busy;
      logic                 rejected;
   } rsp_payload_type;

endpackage

// ===== hw/rtl/lzp_stream_if.sv =====
interface lzp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/lzp_ram.sv =====
module lzp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word until the next read
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lzp_word_stream_decoder_top.sv =====
// LZP-style decoder for a stream of 16-bit words with an order-3 context check.
// req_bus carries one beat per item: operation (word arrives / tick) and word.
// rsp_bus returns exactly one beat per request beat: value, value_valid,
// run_busy and rejected.
// A request beat lands in a one-entry input buffer; the decode sequencer takes
// it from there, so the next beat is accepted while the current one is at work.
// The buffer takes no new beat until the sequencer has taken the one it holds.
// Results sit in an output register, so a stalled receiver holds only that
// register: the sequencer waits to finish its item, the input buffer fills,
// and then req_bus.ready drops.
// A literal, a rejected word or an idle tick finishes straight from the input
// buffer; a copy tick first reads one window word; a word that runs the
// context check reads the history table, then one to three window words, each
// read registered. The sequencer works on one item at a time, until its serial
// table and window reads are done.
// The last three output words live in registers, so the check reads only the
// predicted side of the window.
// After reset the history table is cleared, one entry a cycle, over all
// 2**HASH_BITS entries; req_bus.ready stays low during the pass. The window is
// not cleared: an unwritten word reads as zero via a write pointer/wrap check.
module lzp_word_stream_decoder_top #(
   parameter int HASH_BITS   = 12,
   parameter int WINDOW_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   lzp_stream_if.sink   req_bus,
   lzp_stream_if.source rsp_bus
);

   localparam int WB         = lzp_pkg::WORD_BITS;
   localparam int HASH_SHIFT = HASH_BITS / 3;

   // sequencer states
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_COPY = 3'd1;
   localparam logic [2:0] S_HT   = 3'd2;
   localparam logic [2:0] S_C1   = 3'd3;
   localparam logic [2:0] S_C2   = 3'd4;
   localparam logic [2:0] S_C3   = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   // control state
   logic [2:0]             state_ff, state_in;
   logic                   clr_busy_ff, clr_busy_in;
   logic [HASH_BITS-1:0]   clr_cnt_ff, clr_cnt_in;
   logic                   buf_valid_ff, buf_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [WINDOW_BITS-1:0] write_pos_ff, write_pos_in;
   logic                   wrapped_ff, wrapped_in;
   logic [HASH_BITS-1:0]   ctx_ff, ctx_in;
   logic [WINDOW_BITS-1:0] copy_pos_ff, copy_pos_in;
   logic [WB-1:0]          run_left_ff, run_left_in;
   logic                   literal_next_ff, literal_next_in;
   logic [WB-1:0]          last1_ff, last1_in;
   logic [WB-1:0]          last2_ff, last2_in;
   logic [WB-1:0]          last3_ff, last3_in;

   // payload registers
   lzp_pkg::req_payload_type buf_ff, buf_in;
   lzp_pkg::rsp_payload_type rsp_ff, rsp_in;
   logic [WB-1:0]            work_word_ff, work_word_in;
   logic [WINDOW_BITS-1:0]   pred_ff, pred_in;
   logic                     match_ff, match_in;
   logic                     win_ok_ff, win_ok_in;

   // sequencer outputs
   logic                   accept;
   logic                   pop;
   logic                   finish;
   logic                   out_free;
   logic                   emit;
   logic [WB-1:0]          emit_value;
   logic                   ht_rd_en;
   logic [WINDOW_BITS-1:0] ht_rd_data;
   logic                   ht_wr_en;
   logic [HASH_BITS-1:0]   ht_wr_addr;
   logic [WINDOW_BITS-1:0] ht_wr_data;
   logic                   win_rd_en;
   logic [WINDOW_BITS-1:0] win_rd_addr;
   logic [WB-1:0]          win_rd_data;
   logic [WB-1:0]          win_word;

   lzp_ram #(
      .WIDTH (WINDOW_BITS),
      .DEPTH (2 ** HASH_BITS)
   ) u_history (
      .clock   (clock),
      .wr_en   (ht_wr_en),
      .wr_addr (ht_wr_addr),
      .wr_data (ht_wr_data),
      .rd_en   (ht_rd_en),
      .rd_addr (ctx_ff),
      .rd_data (ht_rd_data)
   );

   lzp_ram #(
      .WIDTH (WB),
      .DEPTH (2 ** WINDOW_BITS)
   ) u_window (
      .clock   (clock),
      .wr_en   (emit),
      .wr_addr (write_pos_ff),
      .wr_data (emit_value),
      .rd_en   (win_rd_en),
      .rd_addr (win_rd_addr),
      .rd_data (win_rd_data)
   );

   assign req_bus.ready   = !buf_valid_ff && !clr_busy_ff;
   assign accept          = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;
   assign out_free        = !rsp_valid_ff || rsp_bus.ready;

   // a window entry not yet written since reset reads as zero
   assign win_word = win_ok_ff ? win_rd_data : '0;
   assign win_ok_in = wrapped_ff || (win_rd_addr < write_pos_ff);

   // decode sequencer
   always_comb begin
      state_in        = state_ff;
      pop             = 1'b0;
      finish          = 1'b0;
      rsp_in          = '0;
      emit            = 1'b0;
      emit_value      = '0;
      ht_rd_en        = 1'b0;
      win_rd_en       = 1'b0;
      win_rd_addr     = copy_pos_ff;
      copy_pos_in     = copy_pos_ff;
      run_left_in     = run_left_ff;
      literal_next_in = literal_next_ff;
      work_word_in    = work_word_ff;
      pred_in         = pred_ff;
      match_in        = match_ff;
      case (state_ff)
         S_IDLE: begin
            if (buf_valid_ff) begin
               if (run_left_ff != '0) begin
                  if (buf_ff.operation == lzp_pkg::OP_TICK) begin
                     // fetch the next word of the run
                     win_rd_en = 1'b1;
                     pop       = 1'b1;
                     state_in  = S_COPY;
                  end else if (out_free) begin
                     // drop a word that arrives during a run
                     finish          = 1'b1;
                     pop             = 1'b1;
                     rsp_in.rejected = 1'b1;
                     rsp_in.run_busy = 1'b1;
                  end
               end else if (buf_ff.operation == lzp_pkg::OP_WORD && !literal_next_ff) begin
                  // start the context check with a history lookup
                  ht_rd_en     = 1'b1;
                  work_word_in = buf_ff.word;
                  pop          = 1'b1;
                  state_in     = S_HT;
               end else if (out_free) begin
                  finish = 1'b1;
                  pop    = 1'b1;
                  if (buf_ff.operation == lzp_pkg::OP_WORD) begin
                     // forced literal after a run
                     literal_next_in    = 1'b0;
                     emit               = 1'b1;
                     emit_value         = buf_ff.word;
                     rsp_in.value       = buf_ff.word;
                     rsp_in.value_valid = 1'b1;
                  end
               end
            end
         end
         S_COPY: begin
            if (out_free) begin
               finish             = 1'b1;
               emit               = 1'b1;
               emit_value         = win_word;
               rsp_in.value       = win_word;
               rsp_in.value_valid = 1'b1;
               rsp_in.run_busy    = (run_left_ff != WB'(1));
               copy_pos_in        = copy_pos_ff + WINDOW_BITS'(1);
               run_left_in        = run_left_ff - WB'(1);
               state_in           = S_IDLE;
            end
         end
         S_HT: begin
            pred_in     = ht_rd_data;
            win_rd_en   = 1'b1;
            win_rd_addr = ht_rd_data - WINDOW_BITS'(1);
            state_in    = S_C1;
         end
         S_C1: begin
            if (win_word != last1_ff) begin
               match_in = 1'b0;
               state_in = S_FIN;
            end else begin
               win_rd_en   = 1'b1;
               win_rd_addr = pred_ff - WINDOW_BITS'(2);
               state_in    = S_C2;
            end
         end
         S_C2: begin
            if (win_word != last2_ff) begin
               match_in = 1'b0;
               state_in = S_FIN;
            end else begin
               win_rd_en   = 1'b1;
               win_rd_addr = pred_ff - WINDOW_BITS'(3);
               state_in    = S_C3;
            end
         end
         S_C3: begin
            match_in = (win_word == last3_ff);
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               finish   = 1'b1;
               state_in = S_IDLE;
               if (match_ff) begin
                  // the word is a repeat count
                  copy_pos_in     = pred_ff;
                  run_left_in     = work_word_ff;
                  literal_next_in = 1'b1;
                  rsp_in.run_busy = (work_word_ff != '0);
               end else begin
                  emit               = 1'b1;
                  emit_value         = work_word_ff;
                  rsp_in.value       = work_word_ff;
                  rsp_in.value_valid = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // history table write: clearing pass after reset, else one entry per output word
   assign ht_wr_en   = clr_busy_ff || emit;
   assign ht_wr_addr = clr_busy_ff ? clr_cnt_ff : ctx_ff;
   assign ht_wr_data = clr_busy_ff ? '0 : write_pos_ff;

   assign clr_cnt_in  = clr_cnt_ff + HASH_BITS'(1);
   assign clr_busy_in = clr_busy_ff && (clr_cnt_ff != '1);

   // every output word advances the hash, the pointer and the last-three shift line
   assign ctx_in       = emit ? ((ctx_ff << HASH_SHIFT) ^ HASH_BITS'(emit_value)) : ctx_ff;
   assign write_pos_in = emit ? (write_pos_ff + WINDOW_BITS'(1)) : write_pos_ff;
   assign wrapped_in   = wrapped_ff || (emit && (write_pos_ff == '1));
   assign last1_in     = emit ? emit_value : last1_ff;
   assign last2_in     = emit ? last1_ff : last2_ff;
   assign last3_in     = emit ? last2_ff : last3_ff;

   assign buf_valid_in = accept ? 1'b1 : (pop ? 1'b0 : buf_valid_ff);
   assign buf_in       = accept ? req_bus.payload : buf_ff;
   assign rsp_valid_in = finish ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         clr_busy_ff     <= 1'b1;
         clr_cnt_ff      <= '0;
         buf_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         write_pos_ff    <= '0;
         wrapped_ff      <= 1'b0;
         ctx_ff          <= '0;
         copy_pos_ff     <= '0;
         run_left_ff     <= '0;
         literal_next_ff <= 1'b0;
         last1_ff        <= '0;
         last2_ff        <= '0;
         last3_ff        <= '0;
      end else begin
         state_ff        <= state_in;
         clr_busy_ff     <= clr_busy_in;
         clr_cnt_ff      <= clr_cnt_in;
         buf_valid_ff    <= buf_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         write_pos_ff    <= write_pos_in;
         wrapped_ff      <= wrapped_in;
         ctx_ff          <= ctx_in;
         copy_pos_ff     <= copy_pos_in;
         run_left_ff     <= run_left_in;
         literal_next_ff <= literal_next_in;
         last1_ff        <= last1_in;
         last2_ff        <= last2_in;
         last3_ff        <= last3_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff       <= buf_in;
      work_word_ff <= work_word_in;
      pred_ff      <= pred_in;
      match_ff     <= match_in;
      if (win_rd_en) begin
         win_ok_ff <= win_ok_in;
      end
      if (finish) begin
         rsp_ff <= rsp_in;
      end
   end

   // no beat is taken while the history table is being cleared
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !accept)
      else $error("request accepted during history clearing pass");

   // a copy tick is only in flight while a run is pending
   a_copy_needs_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY) |-> (run_left_ff != '0))
      else $error("copy state entered with no run pending");

   // a rejected word never carries a decoded value and always reports a run
   a_reject_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.rejected) |-> (!rsp_ff.value_valid && rsp_ff.run_busy))
      else $error("rejected result carries a value or no run");

   // each output word advances the write pointer by one
   a_emit_advances: assert property (@(posedge clock) disable iff (reset)
      emit |=> (write_pos_ff == $past(write_pos_ff) + WINDOW_BITS'(1)))
      else $error("write pointer did not advance on an output word");

endmodule

// ===== tb/sv/lzp_word_stream_decoder_top_tb.sv =====
`timescale 1ns / 100ps

module lzp_word_stream_decoder_top_tb;

   localparam int HASH_BITS     = 12;
   localparam int WINDOW_BITS   = 16;
   localparam int CONTEXT_ORDER = 3;
   // Longest quiet stretch is the table clear after reset; a receiver hold-off is
   // shorter. Leave plenty of margin on both.
   localparam int QUIET_LIMIT    = 20000;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int SETTLE_CYCLES  = 12;

   typedef logic [lzp_pkg::WORD_BITS-1:0] word_type;
   typedef logic [WINDOW_BITS-1:0]        wpos_type;
   typedef logic [HASH_BITS-1:0]          hash_type;

   logic clock = 1'b0;
   logic reset;

   lzp_stream_if #(.payload_type(lzp_pkg::req_payload_type)) req_bus ();
   lzp_stream_if #(.payload_type(lzp_pkg::rsp_payload_type)) rsp_bus ();

   lzp_word_stream_decoder_top #(
      .HASH_BITS  (HASH_BITS),
      .WINDOW_BITS(WINDOW_BITS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Decoder shadow: table of predicted positions, output window, hash and
   // run state, advanced once per accepted request beat.
   // ---------------------------------------------------------------------
   wpos_type hist_pos [0:(1<<HASH_BITS)-1];
   word_type win_words [0:(1<<WINDOW_BITS)-1];
   wpos_type write_pos;
   hash_type ctx_hash;
   wpos_type copy_pos;
   word_type run_left;
   logic     literal_next;

   lzp_pkg::rsp_payload_type decoded_fifo [$];
   word_type                 replay_words [$];

   int req_beats, rsp_beats, mismatch_count;
   int n_literals, n_copies, n_runs, n_zero_runs, n_rejects, n_idle_ticks;
   int burst_left;
   bit holdoff_flip;

   task automatic clear_shadow();
      foreach (hist_pos[i]) hist_pos[i] = '0;
      foreach (win_words[i]) win_words[i] = '0;
      write_pos    = '0;
      ctx_hash     = '0;
      copy_pos     = '0;
      run_left     = '0;
      literal_next = 1'b0;
   endtask

   // Record one output word: table entry, hash, window, write position.
   function automatic void append_output(word_type w);
      hist_pos[ctx_hash]   = write_pos;
      ctx_hash             = hash_type'((ctx_hash << (HASH_BITS / 3)) ^ w);
      win_words[write_pos] = w;
      write_pos            = write_pos + 1'b1;
   endfunction

   // The three words ahead of pred must equal the last three written.
   function automatic bit context_hit(wpos_type pred);
      wpos_type k;
      for (k = 1; k <= CONTEXT_ORDER; k++) begin
         if (win_words[wpos_type'(pred - k)] != win_words[wpos_type'(write_pos - k)])
            return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic bit count_word_due();
      return run_left == 0 && !literal_next && context_hit(hist_pos[ctx_hash]);
   endfunction

   function automatic lzp_pkg::rsp_payload_type decode_word_beat(
      lzp_pkg::req_payload_type beat);
      lzp_pkg::rsp_payload_type r;
      wpos_type                 pred;
      r = '0;
      if (run_left != 0) begin
         if (beat.operation == lzp_pkg::OP_TICK) begin
            r.value       = win_words[copy_pos];
            r.value_valid = 1'b1;
            copy_pos      = copy_pos + 1'b1;
            append_output(r.value);
            run_left      = run_left - 1'b1;
            n_copies++;
         end else begin
            r.rejected = 1'b1;
            n_rejects++;
         end
      end else if (beat.operation == lzp_pkg::OP_WORD) begin
         pred = hist_pos[ctx_hash];
         if (!literal_next && context_hit(pred)) begin
            copy_pos     = pred;
            run_left     = beat.word;
            literal_next = 1'b1;
            n_runs++;
            if (beat.word == 0) n_zero_runs++;
         end else begin
            literal_next  = 1'b0;
            r.value       = beat.word;
            r.value_valid = 1'b1;
            append_output(beat.word);
            n_literals++;
         end
      end else begin
         n_idle_ticks++;
      end
      r.run_busy = (run_left != 0);
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Present one beat at the falling edge, hold it until accepted, then
   // predict its result. Valid stays high for a following beat.
   task automatic send_beat(logic op, word_type w);
      lzp_pkg::req_payload_type beat;
      beat.operation = op;
      beat.word      = w;
      @(negedge clock);
      req_bus.valid   = 1'b1;
      req_bus.payload = beat;
      do @(posedge clock); while (!req_bus.ready);
      req_beats++;
      decoded_fifo.insert(decoded_fifo.size(), decode_word_beat(beat));
   endtask

   task automatic idle_gap(int cycles);
      @(negedge clock);
      req_bus.valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Force a literal: retire a pending count with a zero count first.
   task automatic push_literal(word_type w);
      if (count_word_due()) send_beat(lzp_pkg::OP_WORD, '0);
      send_beat(lzp_pkg::OP_WORD, w);
   endtask

   task automatic drain_results();
      while (decoded_fifo.size() != 0) @(posedge clock);
   endtask

   // Pick the next beat from the shadow state so that most traffic is well
   // formed: counts when the context matches, ticks while a run is pending,
   // literals that replay recent output so that contexts recur.
   task automatic traffic_beat();
      word_type w;
      int       back;
      if (run_left != 0) begin
         if ($urandom_range(0, 9) == 0) send_beat(lzp_pkg::OP_WORD, word_type'($urandom));
         else send_beat(lzp_pkg::OP_TICK, word_type'($urandom));
      end else if (count_word_due()) begin
         case ($urandom_range(0, 19))
            0, 1, 2:         w = '0;
            3, 4, 5, 6:      w = word_type'($urandom_range(9, 40));
            default:         w = word_type'($urandom_range(1, 8));
         endcase
         send_beat(lzp_pkg::OP_WORD, w);
      end else if ($urandom_range(0, 15) == 0) begin
         send_beat(lzp_pkg::OP_TICK, word_type'($urandom));
      end else begin
         if (replay_words.size() == 0) begin
            if ($urandom_range(0, 99) < 55) begin
               back = $urandom_range(3, 80);
               repeat ($urandom_range(3, 5)) begin
                  replay_words.insert(replay_words.size(),
                                      win_words[wpos_type'(write_pos - back)]);
                  back--;
               end
            end else if ($urandom_range(0, 1)) begin
               replay_words.insert(replay_words.size(), word_type'($urandom));
            end else begin
               case ($urandom_range(0, 3))
                  0:       replay_words.insert(replay_words.size(), 16'h0000);
                  1:       replay_words.insert(replay_words.size(), 16'h0001);
                  2:       replay_words.insert(replay_words.size(), 16'h8000);
                  default: replay_words.insert(replay_words.size(), 16'hFFFF);
               endcase
            end
         end
         send_beat(lzp_pkg::OP_WORD, replay_words.pop_front());
      end
   endtask

   // Bursts of random length, with random gaps between them when with_gaps is set.
   task automatic random_traffic(int beats, bit with_gaps);
      repeat (beats) begin
         traffic_beat();
         burst_left = burst_left - 1;
         if (burst_left <= 0) begin
            if (with_gaps) idle_gap($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed_cases();
      // tick with nothing pending right after reset
      send_beat(lzp_pkg::OP_TICK, 16'hFFFF);
      // cleared table and window: the zero context matches, so this is a count
      send_beat(lzp_pkg::OP_WORD, 16'd3);
      // word while the run is pending
      send_beat(lzp_pkg::OP_WORD, 16'h1234);
      // the run copies from its own output position
      repeat (3) send_beat(lzp_pkg::OP_TICK, 16'h0000);
      // stray tick between the run and its closing literal
      send_beat(lzp_pkg::OP_TICK, 16'h5A5A);
      send_beat(lzp_pkg::OP_WORD, 16'hFFFF);
      push_literal(16'h0000);
      push_literal(16'hFFFF);
      push_literal(16'h8001);
      push_literal(16'h7FFE);
      // repeated word: the copy source overlaps the words being written
      repeat (4) push_literal(16'h00F0);
      if (count_word_due()) begin
         send_beat(lzp_pkg::OP_WORD, 16'd6);
         repeat (6) send_beat(lzp_pkg::OP_TICK, 16'h0000);
      end
      push_literal(16'hA5C3);
      // same context again, closed by a zero count
      repeat (3) push_literal(16'h00F0);
      if (count_word_due()) send_beat(lzp_pkg::OP_WORD, 16'h0000);
   endtask

   task automatic test_random_stream(int beats);
      random_traffic(beats, 1'b1);
   endtask

   // Receiver holds off while the sender keeps offering back to back, so the
   // block fills and drops its request ready.
   task automatic test_receiver_holdoff(int beats);
      holdoff_flip = ~holdoff_flip;
      random_traffic(beats, 1'b0);
   endtask

   // Sender stops until every result is back, then resumes.
   task automatic test_drain_pause(int beats);
      idle_gap(1);
      drain_results();
      random_traffic(beats, 1'b1);
   endtask

   // ---------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      mismatch_count++;
      $display("rsp beat %0d: %s expected %h, got %h", rsp_beats, what, want, got);
   endtask

   // Receiver ready pattern; a flip of holdoff_flip starts a long hold-off.
   initial begin : rsp_stall
      int cyc;
      int hold_left;
      int mode;
      bit seen_flip;
      rsp_bus.ready = 1'b0;
      cyc       = 0;
      hold_left = 0;
      mode      = 0;
      seen_flip = 1'b0;
      forever begin
         @(negedge clock);
         cyc++;
         if (holdoff_flip != seen_flip) begin
            seen_flip = holdoff_flip;
            hold_left = HOLDOFF_CYCLES;
         end
         if (cyc % 64 == 0) mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready = 1'b0;
         end else begin
            case (mode)
               0:       rsp_bus.ready = 1'b1;
               1:       rsp_bus.ready = ($urandom_range(0, 9) < 6);
               2:       rsp_bus.ready = (cyc % 5 != 0) && (cyc % 7 != 3);
               default: rsp_bus.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Compare each result beat with the oldest prediction.
   always @(posedge clock) begin
      lzp_pkg::rsp_payload_type got;
      lzp_pkg::rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = rsp_bus.payload;
         if (decoded_fifo.size() == 0) begin
            report_mismatch("unexpected beat", 0, 32'(got));
         end else begin
            want = decoded_fifo.pop_front();
            if (got.value !== want.value)
               report_mismatch("value", 32'(want.value), 32'(got.value));
            if (got.value_valid !== want.value_valid)
               report_mismatch("value_valid", 32'(want.value_valid), 32'(got.value_valid));
            if (got.run_busy !== want.run_busy)
               report_mismatch("run_busy", 32'(want.run_busy), 32'(got.run_busy));
            if (got.rejected !== want.rejected)
               report_mismatch("rejected", 32'(want.rejected), 32'(got.rejected));
         end
         rsp_beats++;
      end
   end

   // Watchdog: end the run if nothing moves on either channel for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("timeout: %0d cycles without a beat", QUIET_LIMIT);
      $display("lzp_word_stream_decoder_top: mismatch");
      $finish;
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.payload = '0;
      holdoff_flip    = 1'b0;
      burst_left      = 1;
      req_beats       = 0;
      rsp_beats       = 0;
      mismatch_count  = 0;
      n_literals      = 0;
      n_copies        = 0;
      n_runs          = 0;
      n_zero_runs     = 0;
      n_rejects       = 0;
      n_idle_ticks    = 0;
      clear_shadow();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_random_stream(200);
      test_receiver_holdoff(40);
      test_drain_pause(180);

      // drop valid, wait for the tail, then give the block time to settle
      idle_gap(1);
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d beats: %0d literals, %0d copied words in %0d runs (%0d empty)",
               req_beats, n_literals, n_copies, n_runs, n_zero_runs);
      $display("  %0d words rejected during runs, %0d ticks ignored, receiver hold-off %0d",
               n_rejects, n_idle_ticks, HOLDOFF_CYCLES);
      if (mismatch_count == 0) begin
         $display("lzp_word_stream_decoder_top: match");
      end else begin
         $display("lzp_word_stream_decoder_top: mismatch");
      end
      $finish;
   end

endmodule
